>>> rtl/ght_pkg.sv
// Shared types, constants and helper functions for the growable handle table.
// Used by ght_ctrl, ght_dp and growable_handle_table_top.
`default_nettype none
package ght_pkg;
    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CAP_W       = IDX_W + 1;
    localparam int REF_W       = 64;
    localparam int CHUNK_W     = 16;
    localparam int POS_W       = $clog2(CHUNK_W);
    localparam int CHK_W       = IDX_W - POS_W;
    localparam int HANDLE_W    = 32;
    localparam int HOUT_W      = 11;
    localparam int STATUS_W    = 3;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 88;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PARAM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CANCELED    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT = 2'd2;

    typedef struct packed {
        logic                load;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                fscan;
        logic                alloc;
        logic                grow;
        logic                rd;
        logic                look_done;
        logic                clr;
        logic                tscan;
        logic                shrink;
        logic                result;
    } ght_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ref_zero;
        logic            dec_ok;
        logic            release_ok;
        logic            top_hit;
        logic            free_found;
        logic            scan_last;
        logic            top_done;
        logic            shrink_done;
        logic            out_free;
    } ght_stat_t;

    function automatic logic [POS_W-1:0] lowest_set(input logic [CHUNK_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--) begin
            if (v[j]) p = POS_W'(j);
        end
        return p;
    endfunction

    function automatic logic [POS_W-1:0] highest_set(input logic [CHUNK_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (v[j]) p = POS_W'(j);
        end
        return p;
    endfunction
endpackage
`default_nettype wire

>>> rtl/ght_ctrl.sv
// Sequencer for the handle table: walks each operation through decode, scans,
// resize and result hand-off. Depends on ght_pkg; drives ght_dp by commands.
`default_nettype none
module ght_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire ght_pkg::ght_stat_t stat,
    output ght_pkg::ght_cmd_t  cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_FSCAN  = 8'b0000_0100,
        S_GROW   = 8'b0000_1000,
        S_LOOK   = 8'b0001_0000,
        S_TSCAN  = 8'b0010_0000,
        S_SHRINK = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } ght_state_t;

    ght_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FIN;
                case (stat.op)
                    ght_pkg::OP_CREATE: begin
                        if (stat.ref_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ght_pkg::ST_BAD_PARAM;
                        end else begin
                            state_next = S_FSCAN;
                        end
                    end
                    ght_pkg::OP_LOOKUP: begin
                        if (!stat.dec_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ght_pkg::ST_BAD_HANDLE;
                        end else begin
                            cmd.rd     = 1'b1;
                            state_next = S_LOOK;
                        end
                    end
                    ght_pkg::OP_DELETE: begin
                        if (!stat.dec_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ght_pkg::ST_BAD_HANDLE;
                        end else if (!stat.release_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ght_pkg::ST_CANCELED;
                        end else begin
                            cmd.clr = 1'b1;
                            if (stat.top_hit) state_next = S_TSCAN;
                        end
                    end
                    default: begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ght_pkg::ST_BAD_PARAM;
                    end
                endcase
            end
            S_FSCAN: begin
                cmd.fscan = 1'b1;
                if (stat.free_found) begin
                    cmd.alloc  = 1'b1;
                    state_next = S_FIN;
                end else if (stat.scan_last) begin
                    state_next = S_GROW;
                end
            end
            S_GROW: begin
                cmd.grow   = 1'b1;
                state_next = S_FIN;
            end
            S_LOOK: begin
                cmd.look_done = 1'b1;
                state_next    = S_FIN;
            end
            S_TSCAN: begin
                cmd.tscan = 1'b1;
                if (stat.top_done) state_next = S_SHRINK;
            end
            S_SHRINK: begin
                cmd.shrink = 1'b1;
                if (stat.shrink_done) state_next = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/ght_dp.sv
// Datapath of the handle table: reference memory, occupancy bits, capacity,
// top index, scan counters, configuration and result register. Uses ght_pkg.
`default_nettype none
module ght_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ght_pkg::ght_cmd_t                   cmd,
    output ght_pkg::ght_stat_t                       stat,
    input  wire logic [ght_pkg::OP_W-1:0]            in_op,
    input  wire logic [ght_pkg::HANDLE_W-1:0]        in_handle,
    input  wire logic [ght_pkg::REF_W-1:0]           in_ref,
    input  wire logic                                in_release,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ght_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ght_pkg::CAP_W-1:0]           cfg_wdata,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [ght_pkg::STATUS_W-1:0]             m_status,
    output logic [ght_pkg::HOUT_W-1:0]               m_handle,
    output logic [ght_pkg::REF_W-1:0]                m_object,
    output logic [ght_pkg::CAP_W-1:0]                m_capacity
);
    localparam int IW = ght_pkg::IDX_W;
    localparam int CW = ght_pkg::CAP_W;
    localparam int PW = ght_pkg::POS_W;
    localparam int KW = ght_pkg::CHK_W;
    localparam int NW = ght_pkg::CHUNK_W;
    localparam logic [CW-1:0] DEPTH = CW'(ght_pkg::MAX_ENTRIES);
    localparam logic [ght_pkg::HOUT_W-1:0] HOUT_W_ONE4 = ght_pkg::HOUT_W'(4);

    logic [ght_pkg::REF_W-1:0] mem [ght_pkg::MAX_ENTRIES];
    logic [ght_pkg::MAX_ENTRIES-1:0] occ_reg;

    logic [CW-1:0] init_reg, step_reg, limit_reg;
    logic [CW-1:0] cap_reg, ncap_reg;
    logic [IW-1:0] top_reg;
    logic [KW-1:0] chunk_reg;

    logic [ght_pkg::OP_W-1:0]     op_reg;
    logic [ght_pkg::HANDLE_W-1:0] handle_reg;
    logic [ght_pkg::REF_W-1:0]    ref_reg;
    logic                         rel_reg;

    logic [ght_pkg::REF_W-1:0]    mem_q_reg;
    logic                         occ_q_reg;
    logic [ght_pkg::STATUS_W-1:0] res_status_reg;
    logic [ght_pkg::HOUT_W-1:0]   res_handle_reg;
    logic [ght_pkg::REF_W-1:0]    res_obj_reg;
    logic                         m_tvalid_reg;

    // effective settings
    logic          lim_lt;
    logic [CW-1:0] eff_init, eff_lim, eff_step;
    assign lim_lt   = limit_reg < init_reg;
    assign eff_init = (init_reg > DEPTH) ? DEPTH : init_reg;
    assign eff_lim  = lim_lt ? init_reg : limit_reg;
    assign eff_step = lim_lt ? '0 : step_reg;

    // handle decode
    logic [ght_pkg::HANDLE_W-3:0] hslot;
    logic                         dec_ok;
    logic [IW-1:0]                dec_idx;
    assign hslot   = handle_reg[ght_pkg::HANDLE_W-1:2];
    assign dec_ok  = (handle_reg != '0) && (handle_reg[1:0] == 2'b00)
                     && (hslot <= (ght_pkg::HANDLE_W-2)'(cap_reg));
    assign dec_idx = IW'(hslot[CW-1:0] - CW'(1));

    // free scan over one chunk of occupancy bits per cycle
    logic [NW-1:0] occ_chunk, free_bits, used_bits;
    logic [CW-1:0] chunk_next_base;
    logic [IW-1:0] free_idx, used_idx;
    always_comb begin
        occ_chunk = occ_reg[{chunk_reg, PW'(0)} +: NW];
        for (int j = 0; j < NW; j++) begin
            free_bits[j] = !occ_chunk[j] && ({1'b0, chunk_reg, PW'(j)} < cap_reg);
            used_bits[j] = occ_chunk[j] && ({chunk_reg, PW'(j)} <= top_reg);
        end
    end
    assign chunk_next_base = {1'b0, chunk_reg, PW'(0)} + CW'(NW);
    assign free_idx = {chunk_reg, ght_pkg::lowest_set(free_bits)};
    assign used_idx = {chunk_reg, ght_pkg::highest_set(used_bits)};

    // grow attempt
    logic [CW:0]   want0, want1;
    logic          grow_fail;
    always_comb begin
        want0     = {1'b0, cap_reg} + {1'b0, eff_step};
        want1     = want0;
        grow_fail = (eff_step == '0);
        if ((eff_lim != '0) && (want0 > {1'b0, eff_lim})) begin
            want1 = {1'b0, eff_lim};
            if (eff_lim <= cap_reg) grow_fail = 1'b1;
        end
        if (want1 > {1'b0, DEPTH}) begin
            want1 = {1'b0, DEPTH};
            if (DEPTH <= cap_reg) grow_fail = 1'b1;
        end
    end

    // one shrink step per cycle
    logic shrink_go;
    assign shrink_go = (eff_step != '0)
                       && ((CW+1)'(top_reg) + (CW+1)'(1) + {1'b0, eff_step} <= {1'b0, ncap_reg})
                       && ({1'b0, eff_init} + {1'b0, eff_step} <= {1'b0, ncap_reg})
                       && (eff_step < ncap_reg);

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        stat             = '0;
        stat.op          = op_reg;
        stat.ref_zero    = (ref_reg == '0);
        stat.dec_ok      = dec_ok;
        stat.release_ok  = rel_reg;
        stat.top_hit     = (dec_idx == top_reg);
        stat.free_found  = |free_bits;
        stat.scan_last   = (chunk_reg == '1) || (chunk_next_base >= cap_reg);
        stat.top_done    = (|used_bits) || (chunk_reg == '0);
        stat.shrink_done = !shrink_go;
        stat.out_free    = out_free;
    end

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg  <= CW'(16);
            step_reg  <= CW'(16);
            limit_reg <= DEPTH;
            cap_reg   <= CW'(16);
            top_reg   <= '0;
            occ_reg   <= '0;
            chunk_reg <= '0;
            ncap_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ght_pkg::REG_INIT_SIZE: begin
                        init_reg <= cfg_wdata;
                        cap_reg  <= (cfg_wdata > DEPTH) ? DEPTH : cfg_wdata;
                        top_reg  <= '0;
                        occ_reg  <= '0;
                    end
                    ght_pkg::REG_GROW_STEP:  step_reg  <= cfg_wdata;
                    ght_pkg::REG_SIZE_LIMIT: limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) chunk_reg <= '0;
            if (cmd.fscan && !(|free_bits)) chunk_reg <= chunk_reg + KW'(1);
            if (cmd.alloc) begin
                occ_reg[free_idx] <= 1'b1;
                if (top_reg < free_idx) top_reg <= free_idx;
            end
            if (cmd.grow && !grow_fail) begin
                occ_reg[cap_reg[IW-1:0]] <= 1'b1;
                if (top_reg < cap_reg[IW-1:0]) top_reg <= cap_reg[IW-1:0];
                cap_reg <= want1[CW-1:0];
            end
            if (cmd.clr) begin
                occ_reg[dec_idx] <= 1'b0;
                chunk_reg        <= top_reg[IW-1:PW];
            end
            if (cmd.tscan) begin
                if (|used_bits) begin
                    top_reg  <= used_idx;
                    ncap_reg <= cap_reg;
                end else if (chunk_reg == '0) begin
                    top_reg  <= '0;
                    ncap_reg <= cap_reg;
                end else begin
                    chunk_reg <= chunk_reg - KW'(1);
                end
            end
            if (cmd.shrink) begin
                if (shrink_go) begin
                    ncap_reg <= ncap_reg - eff_step;
                end else if (!((eff_lim != '0) && (ncap_reg > eff_lim))) begin
                    cap_reg <= ncap_reg;
                end
            end
        end
    end

    // reference memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.alloc) mem[free_idx] <= ref_reg;
        if (cmd.grow && !grow_fail) mem[cap_reg[IW-1:0]] <= ref_reg;
        if (cmd.rd) begin
            mem_q_reg <= mem[dec_idx];
            occ_q_reg <= occ_reg[dec_idx];
        end
    end

    // input capture and result staging
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= in_op;
            handle_reg     <= in_handle;
            ref_reg        <= in_ref;
            rel_reg        <= in_release;
            res_status_reg <= ght_pkg::ST_OK;
            res_handle_reg <= '0;
            res_obj_reg    <= '0;
        end
        if (cmd.set_status) res_status_reg <= cmd.status;
        if (cmd.alloc) res_handle_reg <= {1'b0, free_idx + IW'(0), 2'b00} + HOUT_W_ONE4;
        if (cmd.grow) begin
            if (grow_fail) res_status_reg <= ght_pkg::ST_TOO_MANY;
            else res_handle_reg <= {1'b0, cap_reg[IW-1:0], 2'b00} + HOUT_W_ONE4;
        end
        if (cmd.look_done) begin
            if (occ_q_reg) res_obj_reg    <= mem_q_reg;
            else           res_status_reg <= ght_pkg::ST_BAD_HANDLE;
        end
        if (cmd.result) begin
            m_status   <= res_status_reg;
            m_handle   <= res_handle_reg;
            m_object   <= res_obj_reg;
            m_capacity <= cap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)        m_tvalid_reg <= 1'b0;
        else if (cmd.result) m_tvalid_reg <= 1'b1;
        else if (m_tready)   m_tvalid_reg <= 1'b0;
    end
    assign m_tvalid = m_tvalid_reg;

    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg <= DEPTH) else $error("capacity above memory depth");
    a_top_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_reg == '0) || ({1'b0, top_reg} < cap_reg)) else $error("top index outside capacity");
    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result |-> out_free) else $error("result overwrote a pending transfer");
    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |=> occ_reg[$past(free_idx)]) else $error("allocated slot not marked used");
endmodule
`default_nettype wire

>>> rtl/growable_handle_table_top.sv
// Top level of the growable handle table: stream channels and config port.
// Instantiates ght_ctrl and ght_dp; uses ght_pkg.
//
// Usage: one operation enters per transfer on the s_ channel (create, lookup
// or delete) and exactly one result leaves per operation on the m_ channel,
// in order. Config registers are written through cfg_wr_en/cfg_index/
// cfg_wdata while no operation is in flight; writing initial_size empties
// the table at once.
// Sequencing: one operation at a time. Rejected operations and deletes of a
// slot below the top index pass decode and then the result stage; a lookup
// also reads the memory in between. Create scans the occupancy bits 16 slots
// per cycle up to the first free slot, and takes a grow step when none is free.
// Delete of the highest used slot scans downward 16 slots per cycle, then
// shrinks one step per cycle and sets the new capacity in a final step.
// s_tready returns in the cycle after the result is issued. Reset (aresetn
// low, synchronous) empties the table, restores capacity 16, step 16, limit
// 256, and drops any pending result. A stalled m_tready holds the result;
// the next operation may be accepted meanwhile and waits at its end until
// the output register frees up.
`default_nettype none
module growable_handle_table_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [1:0] operation, [33:2] handle, [97:34] object_ref, [98] release_ok
    input  wire logic [ght_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [2:0] status, [13:3] handle_out, [77:14] object_out, [86:78] capacity_now
    output logic [ght_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ght_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ght_pkg::CAP_W-1:0]          cfg_wdata
);
    ght_pkg::ght_cmd_t  cmd;
    ght_pkg::ght_stat_t stat;

    logic [ght_pkg::STATUS_W-1:0] m_status;
    logic [ght_pkg::HOUT_W-1:0]   m_handle;
    logic [ght_pkg::REF_W-1:0]    m_object;
    logic [ght_pkg::CAP_W-1:0]    m_capacity;

    ght_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ght_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[1:0]),
        .in_handle  (s_tdata[33:2]),
        .in_ref     (s_tdata[97:34]),
        .in_release (s_tdata[98]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_status   (m_status),
        .m_handle   (m_handle),
        .m_object   (m_object),
        .m_capacity (m_capacity)
    );

    assign m_tdata = {1'b0, m_capacity, m_object, m_handle, m_status};
endmodule
`default_nettype wire
